@@ sv/tkh_pkg.sv @@
// Package for the top-K min-heap selector.
// It holds the field widths, the register map and the result record.
// No dependencies.
package tkh_pkg;

    localparam int VAL_W   = 32;
    localparam int ENT_W   = 7;
    localparam int CAP_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register map, by word index.
    localparam int REG_CAPACITY = 0;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ENT_W-1:0] entries;
        logic             accepted;
        logic             valid_res;
        logic             last;
    } t_result;

endpackage

@@ sv/tkh_core.sv @@
// Heap sequencer for the top-K selector: heap memory, fill count and the compare logic.
// It depends on tkh_pkg.
module tkh_core
    import tkh_pkg::*;
#(
    parameter int HEAP_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_cmd,
    input  logic [VAL_W-1:0] i_value,
    input  logic [CAP_W-1:0] i_cap,
    input  logic             i_take,
    output logic             o_busy,
    output logic             o_res_req,
    output t_result          o_res
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = AW + 2;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SU_RD  = 9'b000000010,
        S_SU_CMP = 9'b000000100,
        S_SD_RD  = 9'b000001000,
        S_SD_CMP = 9'b000010000,
        S_EMIT   = 9'b000100000,
        S_DR_POP = 9'b001000000,
        S_DR_RD  = 9'b010000000,
        S_DR_LD  = 9'b100000000
    } t_state;

    typedef enum logic {
        CMD_OFFER = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_pos, n_pos;
    logic [VAL_W-1:0] r_v, n_v;
    logic             r_acc, n_acc;
    logic             r_drain, n_drain;
    logic [VAL_W-1:0] r_min;

    logic [VAL_W-1:0] r_mem [HEAP_DEPTH];
    logic [VAL_W-1:0] r_rd_a, r_rd_b;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    rd_addr_a, rd_addr_b;

    logic [IW-1:0]    idx_l, idx_r, idx_fill;
    logic [AW-1:0]    parent;
    logic             l_ok, r_ok, sel_l, sel_r;
    logic [VAL_W-1:0] best;

    assign idx_l    = IW'({r_pos, 1'b1});
    assign idx_r    = idx_l + IW'(1);
    assign idx_fill = IW'(r_fill);
    assign parent   = (r_pos - AW'(1)) >> 1;

    // The value being sifted down is held in r_v rather than in the memory.
    assign l_ok  = idx_l < idx_fill;
    assign r_ok  = idx_r < idx_fill;
    assign sel_l = l_ok && (r_rd_a < r_v);
    assign best  = sel_l ? r_rd_a : r_v;
    assign sel_r = r_ok && (r_rd_b < best);

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_pos     = r_pos;
        n_v       = r_v;
        n_acc     = r_acc;
        n_drain   = r_drain;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_v;
        rd_addr_a = parent;
        rd_addr_b = idx_r[AW-1:0];
        o_res_req = 1'b0;
        o_res.value     = (r_fill != '0) ? r_min : '0;
        o_res.entries   = ENT_W'(r_fill);
        o_res.accepted  = r_acc;
        o_res.valid_res = (r_fill != '0);
        o_res.last      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_drain = (i_cmd == CMD_DRAIN);
                    n_acc   = 1'b0;
                    if (i_cmd == CMD_DRAIN) begin
                        n_state = (r_fill == '0) ? S_EMIT : S_DR_POP;
                    end else if (CAP_W'(r_fill) < i_cap) begin
                        n_v     = i_value;
                        n_pos   = AW'(r_fill);
                        n_fill  = r_fill + CW'(1);
                        n_acc   = 1'b1;
                        n_state = S_SU_RD;
                    end else if ((i_cap != '0) && (r_fill != '0) && (i_value > r_min)) begin
                        n_v     = i_value;
                        n_pos   = '0;
                        n_acc   = 1'b1;
                        n_state = S_SD_RD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SU_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                mem_we = 1'b1;
                if (r_rd_a <= r_v) begin
                    n_state = S_EMIT;
                end else begin
                    mem_wdata = r_rd_a;
                    n_pos     = parent;
                    n_state   = S_SU_RD;
                end
            end
            S_SD_RD: begin
                rd_addr_a = idx_l[AW-1:0];
                rd_addr_b = idx_r[AW-1:0];
                n_state   = S_SD_CMP;
            end
            S_SD_CMP: begin
                mem_we = 1'b1;
                priority if (sel_r) begin
                    mem_wdata = r_rd_b;
                    n_pos     = idx_r[AW-1:0];
                    n_state   = S_SD_RD;
                end else if (sel_l) begin
                    mem_wdata = r_rd_a;
                    n_pos     = idx_l[AW-1:0];
                    n_state   = S_SD_RD;
                end else begin
                    n_state = r_drain ? S_DR_POP : S_EMIT;
                end
            end
            S_EMIT: begin
                o_res_req = 1'b1;
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            S_DR_POP: begin
                o_res_req       = 1'b1;
                o_res.value     = r_min;
                o_res.entries   = ENT_W'(r_fill - CW'(1));
                o_res.accepted  = 1'b0;
                o_res.valid_res = 1'b1;
                o_res.last      = (r_fill == CW'(1));
                if (i_take) begin
                    n_fill  = r_fill - CW'(1);
                    n_state = (r_fill == CW'(1)) ? S_IDLE : S_DR_RD;
                end
            end
            S_DR_RD: begin
                rd_addr_a = AW'(r_fill);
                n_state   = S_DR_LD;
            end
            S_DR_LD: begin
                n_v     = r_rd_a;
                n_pos   = '0;
                n_state = S_SD_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_drain <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_v   <= n_v;
        r_acc <= n_acc;
        if (mem_we && (mem_waddr == '0)) begin
            r_min <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idx_fill <= IW'(HEAP_DEPTH))
        else $error("fill count beyond heap depth");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (IW'(mem_waddr) < idx_fill))
        else $error("heap write outside the live entries");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DR_POP) |-> (r_fill != '0))
        else $error("drain pop from an empty heap");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy)
        else $error("accepted item did not occupy the sequencer");
`endif

endmodule

@@ sv/top_k_min_heap_selector.sv @@
// Top level of the top-K min-heap selector: register port, result register and heap sequencer.
// It depends on tkh_pkg and tkh_core.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-------------------------------------------
//  in       | input     | i_in_valid / o_in_stall    | i_in_cmd, i_in_value
//  out      | output    | o_out_valid / i_out_stall  | o_result_value, o_entries, o_accepted,
//           |           |                            | o_valid_res, o_last
//  config   | input     | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// An offer walks the heap one level at a time, reading the level and then comparing and
// writing back. A drain produces one result per entry, with a sift-down between results. The
// pace is set by the compare logic and the one write port of the heap memory, whose read
// data is registered.
// Reset is synchronous and active low; it empties the heap without a clearing pass.
// A stalled result is held in the output register while the next item may still be taken.
module top_k_min_heap_selector
    import tkh_pkg::*;
#(
    parameter int HEAP_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input item channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_in_cmd,
    input  logic [VAL_W-1:0]   i_in_value,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VAL_W-1:0]   o_result_value,
    output logic [ENT_W-1:0]   o_entries,
    output logic               o_accepted,
    output logic               o_valid_res,
    output logic               o_last,
    // Register port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] cap_eff;
    logic             reg_hit;
    logic             cfg_write;

    logic             core_busy;
    logic             core_req;
    t_result          core_res;
    logic             out_free;
    logic             start;

    logic             r_out_valid;
    t_result          r_out;

    // The register port never waits. Only the word index decides the register hit.
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_CAPACITY));
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (psel && reg_hit) ? PDATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_write && reg_hit) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // A capacity above the built heap size behaves as the heap size.
    assign cap_eff = (r_cap > CAP_W'(HEAP_DEPTH)) ? CAP_W'(HEAP_DEPTH) : r_cap;

    // New items are taken only while the sequencer is idle.
    assign o_in_stall = core_busy;
    assign start      = i_in_valid && !core_busy;

    tkh_core #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_in_cmd),
        .i_value   (i_in_value),
        .i_cap     (cap_eff),
        .i_take    (out_free),
        .o_busy    (core_busy),
        .o_res_req (core_req),
        .o_res     (core_res)
    );

    // The output register can take a new result when it is empty or its transfer completes now.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_req && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_req && out_free) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out.value;
    assign o_entries      = r_out.entries;
    assign o_accepted     = r_out.accepted;
    assign o_valid_res    = r_out.valid_res;
    assign o_last         = r_out.last;

endmodule
